>>> hdl/mmps_pkg.sv
// Package for the max-min pheromone store: table sizes, data widths, request
// and register codes, and the operation codes of the shared trail update unit.
// Depends on nothing; mmps_alu, the top level and the testbench import it.
`default_nettype none

package mmps_pkg;

   // Table sizes.
   localparam int MAX_NODES = 64;
   localparam int MAX_CARS  = 16;

   // Fixed field widths.
   localparam int TRAIL_W     = 32;
   localparam int KEEP_W      = 16;
   localparam int REQ_TYPE_W  = 3;
   localparam int NODE_FLD_W  = 6;
   localparam int CAR_FLD_W   = 4;
   localparam int NUM_NODES_W = 7;
   localparam int NUM_CARS_W  = 5;
   localparam int CSR_INDEX_W = 3;

   // Derived index, count and address widths.
   localparam int NODE_IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CAR_IDX_W  = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
   localparam int COL_W      = (NODE_IDX_W > CAR_IDX_W) ? NODE_IDX_W : CAR_IDX_W;
   localparam int NODE_CNT_W = $clog2(MAX_NODES + 1);
   localparam int CAR_CNT_W  = $clog2(MAX_CARS + 1);
   localparam int NODE_DEPTH = MAX_NODES * MAX_NODES;
   localparam int CAR_DEPTH  = MAX_NODES * MAX_CARS;
   localparam int NODE_AW    = $clog2(NODE_DEPTH);
   localparam int CAR_AW     = $clog2(CAR_DEPTH);
   localparam int ADDR_W     = (NODE_AW > CAR_AW) ? NODE_AW : CAR_AW;

   // Request codes. The two spare codes change nothing and answer zero, ok.
   typedef enum logic [REQ_TYPE_W-1:0] {
      REQ_READ_NODE = 3'd0,
      REQ_READ_CAR  = 3'd1,
      REQ_DEPOSIT   = 3'd2,
      REQ_EVAPORATE = 3'd3,
      REQ_CLAMP     = 3'd4,
      REQ_RESET     = 3'd5,
      REQ_SPARE6    = 3'd6,
      REQ_SPARE7    = 3'd7
   } req_code_type;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NODE_KEEP = 3'd0,
      CSR_CAR_KEEP  = 3'd1,
      CSR_NODE_MAX  = 3'd2,
      CSR_NODE_MIN  = 3'd3,
      CSR_CAR_MAX   = 3'd4,
      CSR_CAR_MIN   = 3'd5,
      CSR_NUM_NODES = 3'd6,
      CSR_NUM_CARS  = 3'd7
   } csr_code_type;

   // Operations of the shared update unit.
   typedef enum logic [1:0] {
      ALU_ADD,
      ALU_SCALE,
      ALU_CLAMP,
      ALU_FILL
   } alu_op_type;

   // Control handed to the update unit for the entry in flight.
   typedef struct packed {
      alu_op_type          op;
      logic                diag;
      logic [KEEP_W-1:0]   keep;
      logic [TRAIL_W-1:0]  lo;
      logic [TRAIL_W-1:0]  hi;
      logic [TRAIL_W-1:0]  amount;
   } alu_ctl_type;

endpackage

`default_nettype wire

>>> hdl/mmps_ram.sv
// Generic single-write, single-read memory with a registered read port.
// Depends on nothing.
`default_nettype none

module mmps_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> hdl/mmps_alu.sv
// Shared trail update unit: saturating deposit, keep-factor scaling,
// clamping to bounds and table fill. Uses mmps_pkg.
`default_nettype none

module mmps_alu
   import mmps_pkg::*;
(
   input  wire alu_ctl_type         ctl,
   input  wire logic [TRAIL_W-1:0]  rd_value,
   output logic      [TRAIL_W-1:0]  result
);

   logic [TRAIL_W:0]          sum;
   logic [TRAIL_W+KEEP_W-1:0] product;
   logic [TRAIL_W-1:0]        capped;

   always_comb begin
      sum     = {1'b0, rd_value} + {1'b0, ctl.amount};
      product = {{KEEP_W{1'b0}}, rd_value} * {{TRAIL_W{1'b0}}, ctl.keep};
      // The upper bound goes first, so a crossed lower bound wins.
      capped  = (rd_value > ctl.hi) ? ctl.hi : rd_value;
      case (ctl.op)
         ALU_ADD:   result = sum[TRAIL_W] ? {TRAIL_W{1'b1}} : sum[TRAIL_W-1:0];
         ALU_SCALE: result = product[TRAIL_W+KEEP_W-1:KEEP_W];
         ALU_CLAMP: result = (capped < ctl.lo) ? ctl.lo : capped;
         ALU_FILL:  result = ctl.diag ? '0 : ctl.hi;
         default:   result = rd_value;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/max_min_pheromone_store.sv
// Max-min pheromone store: node-to-node and node-to-car trail tables with
// the sequencer that walks them through one shared update unit.
// Uses mmps_pkg, mmps_ram and mmps_alu.
`default_nettype none

// The block holds two trail tables of unsigned Q16.16 values, node by node
// and node by car, each in its own memory. One item runs at a time and the
// request side is ready only while the sequencer is idle. A read passes
// through its table's state and the drain step, a deposit through the
// node and car table states and the drain step, and an out-of-range or
// unknown request straight to the drain step. Evaporate, clamp and reset
// sweep every entry in use through the single update unit at one entry
// per cycle; the rate is set by the one read and one write port of each
// table memory. A finished result waits in the output register while the
// next item is accepted and worked on. The tables hold no defined value
// until a reset request has filled them, and nothing clears them after a
// hardware reset. The diagonal of the node table is set to zero by a reset
// request and is left alone by evaporate and clamp. Configuration must be
// written only while the block is idle.

module max_min_pheromone_store
   import mmps_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [REQ_TYPE_W-1:0]   req_type,
   input  wire logic [NODE_FLD_W-1:0]   req_from_node,
   input  wire logic [NODE_FLD_W-1:0]   req_to_node,
   input  wire logic [CAR_FLD_W-1:0]    req_car_index,
   input  wire logic [TRAIL_W-1:0]      req_amount,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [TRAIL_W-1:0]      rsp_read_value,
   output logic                         rsp_status,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [TRAIL_W-1:0]      csr_write_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_NODE,
      S_CAR,
      S_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      SEL_NONE,
      SEL_NODE,
      SEL_CAR
   } rd_sel_type;

   // Configuration registers.
   logic [KEEP_W-1:0]      node_keep_ff, car_keep_ff;
   logic [TRAIL_W-1:0]     node_max_ff, node_min_ff, car_max_ff, car_min_ff;
   logic [NUM_NODES_W-1:0] num_nodes_ff;
   logic [NUM_CARS_W-1:0]  num_cars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_keep_ff <= KEEP_W'(58982);
         car_keep_ff  <= KEEP_W'(58982);
         node_max_ff  <= TRAIL_W'(65536);
         node_min_ff  <= TRAIL_W'(655);
         car_max_ff   <= TRAIL_W'(65536);
         car_min_ff   <= TRAIL_W'(655);
         num_nodes_ff <= NUM_NODES_W'(64);
         num_cars_ff  <= NUM_CARS_W'(16);
      end else if (csr_write_enable) begin
         unique case (csr_code_type'(csr_index))
            CSR_NODE_KEEP: node_keep_ff <= csr_write_data[KEEP_W-1:0];
            CSR_CAR_KEEP:  car_keep_ff  <= csr_write_data[KEEP_W-1:0];
            CSR_NODE_MAX:  node_max_ff  <= csr_write_data;
            CSR_NODE_MIN:  node_min_ff  <= csr_write_data;
            CSR_CAR_MAX:   car_max_ff   <= csr_write_data;
            CSR_CAR_MIN:   car_min_ff   <= csr_write_data;
            CSR_NUM_NODES: num_nodes_ff <= csr_write_data[NUM_NODES_W-1:0];
            CSR_NUM_CARS:  num_cars_ff  <= csr_write_data[NUM_CARS_W-1:0];
            default: ;
         endcase
      end
   end

   // Counts in use, limited to the table sizes.
   logic [NODE_CNT_W-1:0] n_eff;
   logic [CAR_CNT_W-1:0]  c_eff;

   assign n_eff = (32'(num_nodes_ff) > MAX_NODES) ? NODE_CNT_W'(MAX_NODES)
                                                  : NODE_CNT_W'(num_nodes_ff);
   assign c_eff = (32'(num_cars_ff) > MAX_CARS) ? CAR_CNT_W'(MAX_CARS)
                                                : CAR_CNT_W'(num_cars_ff);

   // Sequencer and pipeline registers.
   state_type             state_ff, state_in;
   logic                  single_ff, single_in;
   logic                  deposit_ff, deposit_in;
   logic                  write_ok_ff, write_ok_in;
   alu_op_type            alu_op_ff, alu_op_in;
   rd_sel_type            rd_sel_ff, rd_sel_in;
   logic                  status_hold_ff, status_hold_in;
   logic [TRAIL_W-1:0]    amount_ff, amount_in;
   logic [NODE_IDX_W-1:0] row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [CAR_IDX_W-1:0]  car_ff, car_in;
   logic                  p_valid_ff, p_valid_in;
   logic                  p_node_ff, p_node_in;
   logic                  p_diag_ff, p_diag_in;
   logic [ADDR_W-1:0]     p_addr_ff, p_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [TRAIL_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                  rsp_status_ff, rsp_status_in;

   logic                  accept;
   logic                  row_ok, col_ok, car_ok;
   logic                  last_row, last_col, diag;
   logic [NODE_AW-1:0]    node_addr;
   logic [CAR_AW-1:0]     car_addr;
   logic                  node_rd_en, car_rd_en, node_we, car_we;
   logic [TRAIL_W-1:0]    node_rd_data, car_rd_data, alu_result;
   alu_ctl_type           alu_ctl;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   assign row_ok = 32'(req_from_node) < 32'(n_eff);
   assign col_ok = 32'(req_to_node) < 32'(n_eff);
   assign car_ok = 32'(req_car_index) < 32'(c_eff);

   assign last_row = (32'(row_ff) + 32'd1) == 32'(n_eff);
   assign last_col = (state_ff == S_NODE) ? ((32'(col_ff) + 32'd1) == 32'(n_eff))
                                          : ((32'(col_ff) + 32'd1) == 32'(c_eff));
   assign diag     = 32'(row_ff) == 32'(col_ff);

   assign node_addr = NODE_AW'(row_ff) * NODE_AW'(MAX_NODES) + NODE_AW'(col_ff);
   assign car_addr  = CAR_AW'(row_ff) * CAR_AW'(MAX_CARS) + CAR_AW'(col_ff);

   assign node_rd_en = (state_ff == S_NODE);
   assign car_rd_en  = (state_ff == S_CAR);

   // Evaporate and clamp leave the node table's diagonal untouched.
   assign node_we = p_valid_ff && p_node_ff && write_ok_ff &&
                    !(p_diag_ff && (alu_op_ff == ALU_SCALE || alu_op_ff == ALU_CLAMP));
   assign car_we  = p_valid_ff && !p_node_ff && write_ok_ff;

   always_comb begin
      state_in       = state_ff;
      single_in      = single_ff;
      deposit_in     = deposit_ff;
      write_ok_in    = write_ok_ff;
      alu_op_in      = alu_op_ff;
      rd_sel_in      = rd_sel_ff;
      status_hold_in = status_hold_ff;
      amount_in      = amount_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      car_in         = car_ff;
      p_valid_in     = 1'b0;
      p_node_in      = p_node_ff;
      p_diag_in      = p_diag_ff;
      p_addr_in      = p_addr_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_value_in   = rsp_value_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               row_in         = NODE_IDX_W'(req_from_node);
               col_in         = COL_W'(req_to_node);
               car_in         = CAR_IDX_W'(req_car_index);
               amount_in      = req_amount;
               single_in      = 1'b1;
               deposit_in     = 1'b0;
               write_ok_in    = 1'b0;
               alu_op_in      = ALU_ADD;
               rd_sel_in      = SEL_NONE;
               status_hold_in = 1'b0;
               state_in       = S_DRAIN;
               case (req_type)
                  REQ_READ_NODE: begin
                     if (row_ok && col_ok) begin
                        rd_sel_in = SEL_NODE;
                        state_in  = S_NODE;
                     end else begin
                        status_hold_in = 1'b1;
                     end
                  end
                  REQ_READ_CAR: begin
                     if (row_ok && car_ok) begin
                        col_in    = COL_W'(req_car_index);
                        rd_sel_in = SEL_CAR;
                        state_in  = S_CAR;
                     end else begin
                        status_hold_in = 1'b1;
                     end
                  end
                  REQ_DEPOSIT: begin
                     if (row_ok && col_ok && car_ok) begin
                        deposit_in  = 1'b1;
                        write_ok_in = 1'b1;
                        state_in    = S_NODE;
                     end else begin
                        status_hold_in = 1'b1;
                     end
                  end
                  REQ_EVAPORATE, REQ_CLAMP, REQ_RESET: begin
                     single_in   = 1'b0;
                     write_ok_in = 1'b1;
                     row_in      = '0;
                     col_in      = '0;
                     case (req_type)
                        REQ_EVAPORATE: alu_op_in = ALU_SCALE;
                        REQ_CLAMP:     alu_op_in = ALU_CLAMP;
                        default:       alu_op_in = ALU_FILL;
                     endcase
                     if (n_eff != '0) begin
                        state_in = S_NODE;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_NODE, S_CAR: begin
            // Issue the read of the current entry; its update is written
            // back in the next cycle while the following entry is read.
            // Only the node table has a diagonal.
            p_valid_in = 1'b1;
            p_node_in  = (state_ff == S_NODE);
            p_diag_in  = (state_ff == S_NODE) && diag;
            p_addr_in  = (state_ff == S_NODE) ? ADDR_W'(node_addr) : ADDR_W'(car_addr);
            if (single_ff || (last_row && last_col)) begin
               row_in = '0;
               col_in = '0;
               if (state_ff == S_CAR) begin
                  state_in = S_DRAIN;
               end else if (single_ff) begin
                  if (deposit_ff) begin
                     row_in   = row_ff;
                     col_in   = COL_W'(car_ff);
                     state_in = S_CAR;
                  end else begin
                     state_in = S_DRAIN;
                  end
               end else begin
                  state_in = (c_eff != '0) ? S_CAR : S_DRAIN;
               end
            end else if (last_col) begin
               col_in = '0;
               row_in = row_ff + NODE_IDX_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         S_DRAIN: begin
            // The last write and any read data land in this cycle; the
            // result waits here only while the previous one is not taken.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_hold_ff;
               case (rd_sel_ff)
                  SEL_NODE: rsp_value_in = node_rd_data;
                  SEL_CAR:  rsp_value_in = car_rd_data;
                  default:  rsp_value_in = '0;
               endcase
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      single_ff      <= single_in;
      deposit_ff     <= deposit_in;
      write_ok_ff    <= write_ok_in;
      alu_op_ff      <= alu_op_in;
      rd_sel_ff      <= rd_sel_in;
      status_hold_ff <= status_hold_in;
      amount_ff      <= amount_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      car_ff         <= car_in;
      p_node_ff      <= p_node_in;
      p_diag_ff      <= p_diag_in;
      p_addr_ff      <= p_addr_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_status     = rsp_status_ff;

   // The update unit sees the bounds and keep factor of the table in flight.
   always_comb begin
      alu_ctl.op     = alu_op_ff;
      alu_ctl.diag   = p_diag_ff;
      alu_ctl.keep   = p_node_ff ? node_keep_ff : car_keep_ff;
      alu_ctl.lo     = p_node_ff ? node_min_ff : car_min_ff;
      alu_ctl.hi     = p_node_ff ? node_max_ff : car_max_ff;
      alu_ctl.amount = amount_ff;
   end

   mmps_alu u_alu (
      .ctl      (alu_ctl),
      .rd_value (p_node_ff ? node_rd_data : car_rd_data),
      .result   (alu_result)
   );

   mmps_ram #(
      .WIDTH (TRAIL_W),
      .DEPTH (NODE_DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (p_addr_ff[NODE_AW-1:0]),
      .wr_data (alu_result),
      .rd_en   (node_rd_en),
      .rd_addr (node_addr),
      .rd_data (node_rd_data)
   );

   mmps_ram #(
      .WIDTH (TRAIL_W),
      .DEPTH (CAR_DEPTH)
   ) u_car_ram (
      .clock   (clock),
      .wr_en   (car_we),
      .wr_addr (p_addr_ff[CAR_AW-1:0]),
      .wr_data (alu_result),
      .rd_en   (car_rd_en),
      .rd_addr (car_addr),
      .rd_data (car_rd_data)
   );

`ifndef SYNTHESIS
   // Every table write is the update of an entry read in the previous cycle.
   a_write_follows_read: assert property (@(posedge clock) disable iff (reset)
      (node_we || car_we) |-> $past(node_rd_en || car_rd_en))
      else $error("table write without a preceding read");

   // Only one table is updated in any cycle.
   a_one_table: assert property (@(posedge clock) disable iff (reset)
      !(node_we && car_we))
      else $error("both tables written in one cycle");

   // No update is left in flight once the sequencer is idle.
   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !p_valid_ff)
      else $error("update in flight while idle");

   // A new result appears only as the sequencer leaves its last step.
   a_rsp_from_drain: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DRAIN))
      else $error("result raised outside the drain step");
`endif

endmodule

`default_nettype wire

>>> tb/tb_max_min_pheromone_store.sv
// Self-checking testbench for the max-min pheromone store: drives requests and
// register writes, predicts every reply with its own copy of both trail tables.
// Depends on mmps_pkg and the max_min_pheromone_store top level only.

module tb_max_min_pheromone_store
   import mmps_pkg::*;
();

   typedef struct {
      logic [TRAIL_W-1:0] value;
      logic               status;
   } trail_reply_type;

   // One register setting plus the number of random items run under it.
   typedef struct {
      bit [KEEP_W-1:0]      node_keep;
      bit [KEEP_W-1:0]      car_keep;
      bit [TRAIL_W-1:0]     node_max;
      bit [TRAIL_W-1:0]     node_min;
      bit [TRAIL_W-1:0]     car_max;
      bit [TRAIL_W-1:0]     car_min;
      bit [NUM_NODES_W-1:0] nodes;
      bit [NUM_CARS_W-1:0]  cars;
      int                   items;
   } trail_setup_type;

   // Trail table tracker: keeps its own copy of both tables and of the
   // registers, works out the reply of every accepted item and holds the
   // replies still owed by the block in arrival order.
   class trail_tracker;
      bit [TRAIL_W-1:0]     node_tab [NODE_DEPTH];
      bit [TRAIL_W-1:0]     car_tab [CAR_DEPTH];
      bit [KEEP_W-1:0]      node_keep;
      bit [KEEP_W-1:0]      car_keep;
      bit [TRAIL_W-1:0]     node_max;
      bit [TRAIL_W-1:0]     node_min;
      bit [TRAIL_W-1:0]     car_max;
      bit [TRAIL_W-1:0]     car_min;
      bit [NUM_NODES_W-1:0] num_nodes;
      bit [NUM_CARS_W-1:0]  num_cars;
      trail_reply_type      owed_replies[$];
      int                   mismatches;
      int                   replies_seen;

      function new();
         node_keep    = 16'd58982;
         car_keep     = 16'd58982;
         node_max     = 32'd65536;
         node_min     = 32'd655;
         car_max      = 32'd65536;
         car_min      = 32'd655;
         num_nodes    = 7'd64;
         num_cars     = 5'd16;
         mismatches   = 0;
         replies_seen = 0;
      endfunction

      function int nodes_in_use();
         return (num_nodes > MAX_NODES) ? MAX_NODES : int'(num_nodes);
      endfunction

      function int cars_in_use();
         return (num_cars > MAX_CARS) ? MAX_CARS : int'(num_cars);
      endfunction

      function int outstanding();
         return owed_replies.size();
      endfunction

      function void write_reg(csr_code_type idx, bit [TRAIL_W-1:0] data);
         case (idx)
            CSR_NODE_KEEP: node_keep = data[KEEP_W-1:0];
            CSR_CAR_KEEP:  car_keep  = data[KEEP_W-1:0];
            CSR_NODE_MAX:  node_max  = data;
            CSR_NODE_MIN:  node_min  = data;
            CSR_CAR_MAX:   car_max   = data;
            CSR_CAR_MIN:   car_min   = data;
            CSR_NUM_NODES: num_nodes = data[NUM_NODES_W-1:0];
            CSR_NUM_CARS:  num_cars  = data[NUM_CARS_W-1:0];
            default: ;
         endcase
      endfunction

      // Evaporation keeps the integer part of value times keep / 2^16.
      function bit [TRAIL_W-1:0] scaled(bit [TRAIL_W-1:0] v, bit [KEEP_W-1:0] k);
         bit [47:0] prod;
         prod = {16'b0, v} * {32'b0, k};
         return prod[47:16];
      endfunction

      // The maximum is applied first, so a minimum above the maximum wins.
      function bit [TRAIL_W-1:0] clamped(bit [TRAIL_W-1:0] v, bit [TRAIL_W-1:0] lo,
                                         bit [TRAIL_W-1:0] hi);
         if (v > hi) v = hi;
         if (v < lo) v = lo;
         return v;
      endfunction

      function bit [TRAIL_W-1:0] sat_sum(bit [TRAIL_W-1:0] a, bit [TRAIL_W-1:0] b);
         bit [TRAIL_W:0] s;
         s = {1'b0, a} + {1'b0, b};
         return s[TRAIL_W] ? {TRAIL_W{1'b1}} : s[TRAIL_W-1:0];
      endfunction

      function void apply_request(req_code_type kind, bit [NODE_FLD_W-1:0] row,
                                  bit [NODE_FLD_W-1:0] col, bit [CAR_FLD_W-1:0] car,
                                  bit [TRAIL_W-1:0] amt);
         int              n;
         int              c;
         int              ni;
         int              ci;
         trail_reply_type reply;
         n = nodes_in_use();
         c = cars_in_use();
         ni = int'(row) * MAX_NODES + int'(col);
         ci = int'(row) * MAX_CARS + int'(car);
         reply.value  = '0;
         reply.status = 1'b0;
         case (kind)
            REQ_READ_NODE: begin
               if (row < n && col < n) reply.value = node_tab[ni];
               else reply.status = 1'b1;
            end
            REQ_READ_CAR: begin
               if (row < n && car < c) reply.value = car_tab[ci];
               else reply.status = 1'b1;
            end
            REQ_DEPOSIT: begin
               // A deposit only lands when all three indexes are in range.
               if (row < n && col < n && car < c) begin
                  node_tab[ni] = sat_sum(node_tab[ni], amt);
                  car_tab[ci]  = sat_sum(car_tab[ci], amt);
               end else begin
                  reply.status = 1'b1;
               end
            end
            REQ_EVAPORATE: begin
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < n; j++)
                     if (i != j)
                        node_tab[i*MAX_NODES+j] = scaled(node_tab[i*MAX_NODES+j], node_keep);
                  for (int j = 0; j < c; j++)
                     car_tab[i*MAX_CARS+j] = scaled(car_tab[i*MAX_CARS+j], car_keep);
               end
            end
            REQ_CLAMP: begin
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < n; j++)
                     if (i != j)
                        node_tab[i*MAX_NODES+j] =
                           clamped(node_tab[i*MAX_NODES+j], node_min, node_max);
                  for (int j = 0; j < c; j++)
                     car_tab[i*MAX_CARS+j] = clamped(car_tab[i*MAX_CARS+j], car_min, car_max);
               end
            end
            REQ_RESET: begin
               for (int i = 0; i < n; i++) begin
                  for (int j = 0; j < n; j++)
                     node_tab[i*MAX_NODES+j] = (i == j) ? '0 : node_max;
                  for (int j = 0; j < c; j++)
                     car_tab[i*MAX_CARS+j] = car_max;
               end
            end
            default: ;
         endcase
         owed_replies.push_back(reply);
      endfunction

      function void check_reply(logic [TRAIL_W-1:0] value, logic status);
         trail_reply_type want;
         replies_seen++;
         if (owed_replies.size() == 0) begin
            $error("reply with no request outstanding: read_value %h status %b",
                   value, status);
            mismatches++;
            return;
         end
         want = owed_replies.pop_front();
         if (value !== want.value) begin
            $error("read_value: expected %h, got %h", want.value, value);
            mismatches++;
         end
         if (status !== want.status) begin
            $error("status: expected %b, got %b", want.status, status);
            mismatches++;
         end
      endfunction
   endclass

   // Clock and block inputs, all at known values from time zero.
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [REQ_TYPE_W-1:0]  req_type = '0;
   logic [NODE_FLD_W-1:0]  req_from_node = '0;
   logic [NODE_FLD_W-1:0]  req_to_node = '0;
   logic [CAR_FLD_W-1:0]   req_car_index = '0;
   logic [TRAIL_W-1:0]     req_amount = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [TRAIL_W-1:0]     rsp_read_value;
   logic                   rsp_status;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [TRAIL_W-1:0]     csr_write_data = '0;

   trail_tracker tracker = new();

   // While calm is set neither side idles, so back-to-back stretches occur
   // between the randomly throttled ones.
   bit              calm = 1'b0;
   int              kind_seen[8];
   int              setups_applied = 0;
   trail_setup_type plan[9];

   max_min_pheromone_store uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_from_node    (req_from_node),
      .req_to_node      (req_to_node),
      .req_car_index    (req_car_index),
      .req_amount       (req_amount),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Watchdog. Most of a correct run goes in whole-table sweeps at the largest
   // counts.
   initial begin
      #24_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Number of cycles a side waits before its next item.
   function automatic int draw_gap();
      if ($urandom_range(0, 59) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 4));
   endfunction

   // Offers one item and returns at the rising edge where it is taken. The
   // payload is changed only at falling edges and held until acceptance.
   task automatic send_request(req_code_type kind, bit [NODE_FLD_W-1:0] row,
                               bit [NODE_FLD_W-1:0] col, bit [CAR_FLD_W-1:0] car,
                               bit [TRAIL_W-1:0] amt);
      int gap;
      gap = draw_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_from_node <= row;
      req_to_node   <= col;
      req_car_index <= car;
      req_amount    <= amt;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.apply_request(kind, row, col, car, amt);
      kind_seen[kind]++;
   endtask

   // Lowers valid and waits until every owed reply has come back, which
   // leaves the block idle and safe for register writes.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_code_type idx, bit [TRAIL_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   // Narrow registers get random junk above their width; only the low bits
   // may take effect.
   function automatic bit [TRAIL_W-1:0] with_noise(bit [TRAIL_W-1:0] value, int width);
      bit [TRAIL_W-1:0] high_mask;
      high_mask = {TRAIL_W{1'b1}} << width;
      return value | ($urandom & high_mask);
   endfunction

   task automatic apply_settings(trail_setup_type s);
      write_csr(CSR_NODE_KEEP, with_noise(TRAIL_W'(s.node_keep), KEEP_W));
      write_csr(CSR_CAR_KEEP, with_noise(TRAIL_W'(s.car_keep), KEEP_W));
      write_csr(CSR_NODE_MAX, s.node_max);
      write_csr(CSR_NODE_MIN, s.node_min);
      write_csr(CSR_CAR_MAX, s.car_max);
      write_csr(CSR_CAR_MIN, s.car_min);
      write_csr(CSR_NUM_NODES, with_noise(TRAIL_W'(s.nodes), NUM_NODES_W));
      write_csr(CSR_NUM_CARS, with_noise(TRAIL_W'(s.cars), NUM_CARS_W));
      @(negedge clock);
      csr_write_enable <= 1'b0;
      setups_applied++;
   endtask

   function automatic trail_setup_type make_setup(
      bit [KEEP_W-1:0] nk, bit [KEEP_W-1:0] ck, bit [TRAIL_W-1:0] nmax,
      bit [TRAIL_W-1:0] nmin, bit [TRAIL_W-1:0] cmax, bit [TRAIL_W-1:0] cmin,
      bit [NUM_NODES_W-1:0] nodes, bit [NUM_CARS_W-1:0] cars, int items);
      trail_setup_type s;
      s.node_keep = nk;
      s.car_keep  = ck;
      s.node_max  = nmax;
      s.node_min  = nmin;
      s.car_max   = cmax;
      s.car_min   = cmin;
      s.nodes     = nodes;
      s.cars      = cars;
      s.items     = items;
      return s;
   endfunction

   // Mostly in-range indexes; one in ten spans the whole field so that the
   // out-of-range path and every index bit get exercised.
   function automatic int pick_index(int count, int field_max);
      if (count > 0 && $urandom_range(0, 9) != 0)
         return int'($urandom_range(0, count - 1));
      return int'($urandom_range(0, field_max));
   endfunction

   // Amounts: small trail-sized values, full random words, values near the
   // top for saturation, and shifted words for a spread of magnitudes.
   function automatic bit [TRAIL_W-1:0] pick_amount();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 32'h0002_0000);
         1: return $urandom;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic random_items(int count);
      int                   n;
      int                   c;
      int                   pick;
      req_code_type         kind;
      bit [NODE_FLD_W-1:0]  row;
      bit [NODE_FLD_W-1:0]  col;
      bit [CAR_FLD_W-1:0]   car;
      n = tracker.nodes_in_use();
      c = tracker.cars_in_use();
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 25)      kind = REQ_READ_NODE;
         else if (pick < 45) kind = REQ_READ_CAR;
         else if (pick < 75) kind = REQ_DEPOSIT;
         else if (pick < 83) kind = REQ_EVAPORATE;
         else if (pick < 91) kind = REQ_CLAMP;
         else if (pick < 96) kind = REQ_RESET;
         else                kind = ($urandom_range(0, 1) != 0) ? REQ_SPARE6 : REQ_SPARE7;
         // Large sweeps are costly; above 600 entries keep only a quarter of them.
         if ((kind == REQ_EVAPORATE || kind == REQ_CLAMP || kind == REQ_RESET) &&
             n * (n + c) > 600 && $urandom_range(0, 3) != 0)
            kind = REQ_DEPOSIT;
         row = NODE_FLD_W'(pick_index(n, MAX_NODES - 1));
         col = NODE_FLD_W'(pick_index(n, MAX_NODES - 1));
         car = CAR_FLD_W'(pick_index(c, MAX_CARS - 1));
         send_request(kind, row, col, car, pick_amount());
      end
   endtask

   // Reply side: stalls a random number of cycles before each item, then
   // holds ready until a reply is taken and checks it.
   initial begin : reply_side
      int stall;
      wait (!reset);
      forever begin
         stall = draw_gap();
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         tracker.check_reply(rsp_read_value, rsp_status);
      end
   end

   initial begin : stimulus
      plan[0] = make_setup(16'd0, 16'hFFFF, 32'd0, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'd0, 7'd5, 5'd3, 150);
      plan[1] = make_setup(16'($urandom), 16'($urandom), 32'h0004_0000, 32'h100,
                           32'h0002_0000, 32'h80, 7'd1, 5'd1, 100);
      plan[2] = make_setup(16'hF000, 16'h8000, 32'h7FFF_FFFF, 32'h10,
                           32'h7FFF_FFFF, 32'h10, 7'd8, 5'd4, 200);
      plan[3] = make_setup(16'($urandom), 16'($urandom), 32'h1_0000, 32'h100,
                           32'h1_0000, 32'h100, 7'd0, 5'd0, 60);
      plan[4] = make_setup(16'd58982, 16'd58982, 32'd65536, 32'd655,
                           32'd65536, 32'd655, 7'd127, 5'd31, 120);
      plan[5] = make_setup(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'd0,
                           32'hFFFF_FFFF, 32'd0, 7'd64, 5'd16, 120);
      plan[6] = make_setup(16'($urandom), 16'd1, 32'h1_0000, 32'h1_0000,
                           32'h0008_0000, 32'h400, 7'd3, 5'd16, 150);
      plan[7] = make_setup(16'h8000, 16'($urandom), 32'h00FF_FFFF, 32'h1,
                           32'h0010_0000, 32'h0, 7'd64, 5'd1, 100);
      plan[8] = make_setup(16'd58982, 16'd58982, 32'd65536, 32'd655,
                           32'd65536, 32'd655, 7'd2, 5'd2, 200);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the power-up registers. The tables hold nothing
      // defined yet, so a table reset at full size comes before any read.
      send_request(REQ_RESET, 6'd0, 6'd0, 4'd0, 32'd0);
      send_request(REQ_READ_NODE, 6'd0, 6'd0, 4'd0, 32'd0);
      send_request(REQ_READ_NODE, 6'd63, 6'd62, 4'd0, 32'd0);
      send_request(REQ_READ_CAR, 6'd63, 6'd0, 4'd15, 32'd0);
      // Deposits on the diagonal are allowed; two full-scale ones saturate.
      send_request(REQ_DEPOSIT, 6'd63, 6'd63, 4'd15, 32'hFFFF_FFFF);
      send_request(REQ_DEPOSIT, 6'd63, 6'd63, 4'd15, 32'hFFFF_FFFF);
      send_request(REQ_READ_NODE, 6'd63, 6'd63, 4'd0, 32'd0);
      send_request(REQ_READ_CAR, 6'd63, 6'd0, 4'd15, 32'd0);
      send_request(REQ_DEPOSIT, 6'd0, 6'd1, 4'd0, 32'd1);
      send_request(REQ_EVAPORATE, 6'd0, 6'd0, 4'd0, 32'd0);
      // The saturated diagonal must survive the evaporate untouched.
      send_request(REQ_READ_NODE, 6'd63, 6'd63, 4'd0, 32'd0);
      send_request(REQ_READ_NODE, 6'd0, 6'd1, 4'd0, 32'd0);
      send_request(REQ_CLAMP, 6'd0, 6'd0, 4'd0, 32'd0);
      send_request(REQ_READ_NODE, 6'd0, 6'd1, 4'd0, 32'd0);
      send_request(REQ_READ_CAR, 6'd63, 6'd0, 4'd15, 32'd0);
      send_request(REQ_SPARE6, 6'd63, 6'd63, 4'd15, 32'hFFFF_FFFF);
      send_request(REQ_SPARE7, 6'd1, 6'd2, 4'd3, 32'h1234_5678);

      // Small tables with crossed node bounds and extreme keep factors:
      // out-of-range indexes, a zeroing evaporate and a minimum that wins.
      drain();
      apply_settings(plan[0]);
      send_request(REQ_READ_NODE, 6'd5, 6'd0, 4'd0, 32'd0);
      send_request(REQ_READ_NODE, 6'd0, 6'd63, 4'd0, 32'd0);
      send_request(REQ_READ_CAR, 6'd0, 6'd0, 4'd3, 32'd0);
      send_request(REQ_DEPOSIT, 6'd4, 6'd4, 4'd3, 32'd100);
      send_request(REQ_DEPOSIT, 6'd0, 6'd5, 4'd0, 32'd100);
      send_request(REQ_EVAPORATE, 6'd0, 6'd0, 4'd0, 32'd0);
      send_request(REQ_CLAMP, 6'd0, 6'd0, 4'd0, 32'd0);
      send_request(REQ_READ_NODE, 6'd1, 6'd2, 4'd0, 32'd0);
      send_request(REQ_READ_NODE, 6'd2, 6'd2, 4'd0, 32'd0);
      send_request(REQ_READ_CAR, 6'd4, 6'd0, 4'd2, 32'd0);

      // Random part, one register setting after another.
      foreach (plan[p]) begin
         drain();
         if (p != 0) apply_settings(plan[p]);
         random_items(plan[p].items);
      end
      drain();
      repeat (8) @(posedge clock);

      if (tracker.outstanding() != 0)
         $error("%0d replies never arrived", tracker.outstanding());
      $display("Sent %0d node reads, %0d car reads, %0d deposits, %0d evaporates, %0d clamps,",
               kind_seen[REQ_READ_NODE], kind_seen[REQ_READ_CAR], kind_seen[REQ_DEPOSIT],
               kind_seen[REQ_EVAPORATE], kind_seen[REQ_CLAMP]);
      $display("%0d table resets and %0d spare codes; %0d replies checked over %0d settings.",
               kind_seen[REQ_RESET], kind_seen[REQ_SPARE6] + kind_seen[REQ_SPARE7],
               tracker.replies_seen, setups_applied);
      if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
